[src/interval_latency_statistics_unit_defines.svh]
// Assertion macros shared by the interval latency statistics unit.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INTERVAL_LATENCY_STATISTICS_UNIT_DEFINES_SVH
`define INTERVAL_LATENCY_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ILSU_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ILSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ilsu_pkg.sv]
// Package for the interval latency statistics unit: opcodes, widths and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package ilsu_pkg;

  localparam int unsigned SEC_W   = 32;
  localparam int unsigned NSEC_W  = 30;
  localparam int unsigned NS_W    = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 4 * NS_W + CNT_W;
  localparam int unsigned DIV_CNT_W   = $clog2(NS_W);

  localparam logic [OP_W-1:0] OP_STOP   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic signed [30:0] NS_PER_SEC = 31'sd1000000000;

  typedef struct packed {
    logic load_start;
    logic load_diff;
    logic mul;
    logic add;
    logic stat_upd;
    logic emit_single;
    logic div_init;
    logic div_step;
    logic emit_report;
  } dp_cmd_t;

  typedef struct packed {
    logic armed;
    logic accum_mode;
    logic out_free;
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[src/ilsu_datapath.sv]
// Datapath of the interval latency statistics unit: start stamp, interval
// arithmetic, statistics, serial divider and output register. Uses ilsu_pkg.
`default_nettype none
`include "interval_latency_statistics_unit_defines.svh"

module ilsu_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ilsu_pkg::dp_cmd_t                 cmd,
  output ilsu_pkg::dp_sts_t                      sts,
  input  wire logic [ilsu_pkg::SEC_W-1:0]        stamp_sec,
  input  wire logic [ilsu_pkg::NSEC_W-1:0]       stamp_nsec,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ilsu_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tuser
);
  import ilsu_pkg::*;

  logic [SEC_W-1:0]      start_sec_r;
  logic [NSEC_W-1:0]     start_ns_r;
  logic                  armed_r;
  logic                  accum_mode_r;
  logic signed [SEC_W:0] d_r;
  logic signed [31:0]    ndiff_r;
  logic signed [NS_W-1:0] prod_r;
  logic [NS_W-1:0]       ival_r;
  logic [NS_W-1:0]       sum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [NS_W-1:0]       min_r;
  logic [NS_W-1:0]       max_r;
  logic [CNT_W-1:0]      rem_r;
  logic [NS_W-1:0]       quot_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [NS_W-1:0]       out_ival_r;
  logic [NS_W-1:0]       out_min_r;
  logic [NS_W-1:0]       out_avg_r;
  logic [NS_W-1:0]       out_max_r;
  logic [CNT_W-1:0]      out_cnt_r;

  logic                  borrow;
  logic signed [SEC_W:0] d_nxt;
  logic signed [31:0]    ndiff_nxt;
  logic signed [NS_W-1:0] prod_nxt;
  logic [CNT_W:0]        rem_sh;
  logic                  rem_ge;
  logic [NS_W-1:0]       min_nxt;
  logic [NS_W-1:0]       max_nxt;
  logic [CNT_W-1:0]      cnt_nxt;

  assign borrow    = stamp_nsec < start_ns_r;
  assign d_nxt     = $signed({1'b0, stamp_sec}) - $signed({1'b0, start_sec_r})
                     - $signed({{SEC_W{1'b0}}, borrow});
  assign ndiff_nxt = $signed({2'b00, stamp_nsec}) - $signed({2'b00, start_ns_r})
                     + (borrow ? 32'sd1000000000 : 32'sd0);
  assign prod_nxt  = NS_W'(d_r) * NS_W'(NS_PER_SEC);

  assign rem_sh = {rem_r, quot_r[NS_W-1]};
  assign rem_ge = rem_sh >= {1'b0, cnt_r};

  assign min_nxt = ((cnt_r == '0) || (ival_r < min_r)) ? ival_r : min_r;
  assign max_nxt = (ival_r > max_r) ? ival_r : max_r;
  assign cnt_nxt = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_sec_r  <= '0;
      start_ns_r   <= '0;
      armed_r      <= 1'b0;
      accum_mode_r <= 1'b0;
      sum_r        <= '0;
      cnt_r        <= '0;
      min_r        <= '0;
      max_r        <= '0;
      div_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        accum_mode_r <= cfg_data;
      end
      if (cmd.load_start) begin
        start_sec_r <= stamp_sec;
        start_ns_r  <= stamp_nsec;
        armed_r     <= 1'b1;
      end
      if (cmd.load_diff) begin
        armed_r <= 1'b0;
      end
      if (cmd.stat_upd) begin
        min_r <= min_nxt;
        max_r <= max_nxt;
        sum_r <= sum_r + ival_r;
        cnt_r <= cnt_nxt;
      end
      if (cmd.div_init) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.emit_single || cmd.emit_report) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.emit_report) begin
        sum_r <= '0;
        cnt_r <= '0;
        min_r <= '0;
        max_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      d_r     <= d_nxt;
      ndiff_r <= ndiff_nxt;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.add) begin
      ival_r <= NS_W'(prod_r + NS_W'(ndiff_r));
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      quot_r <= sum_r;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? CNT_W'(rem_sh - {1'b0, cnt_r}) : rem_sh[CNT_W-1:0];
      quot_r <= {quot_r[NS_W-2:0], rem_ge};
    end
    if (cmd.emit_single) begin
      out_kind_r <= KIND_SINGLE;
      out_ival_r <= ival_r;
      out_min_r  <= '0;
      out_avg_r  <= '0;
      out_max_r  <= '0;
      out_cnt_r  <= '0;
    end else if (cmd.emit_report) begin
      out_kind_r <= KIND_REPORT;
      out_ival_r <= '0;
      out_min_r  <= min_r;
      out_avg_r  <= (cnt_r == '0) ? '0 : quot_r;
      out_max_r  <= max_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign cfg_ready = 1'b1;

  assign sts.armed      = armed_r;
  assign sts.accum_mode = accum_mode_r;
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.div_last   = div_cnt_r == '1;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_cnt_r, out_max_r, out_avg_r, out_min_r, out_ival_r};

  `ILSU_ASSERT_IMM(a_emit_has_room, cmd.emit_single || cmd.emit_report, !out_valid_r || out_tready, "result emitted over an untaken result")
  `ILSU_ASSERT_NEXT(a_stop_disarms, cmd.load_diff, !armed_r, "stop left the block armed")
  `ILSU_ASSERT_NEXT(a_cnt_monotonic, !cmd.emit_report, cnt_r >= $past(cnt_r), "sample count fell without a report")

endmodule

`default_nettype wire

[src/ilsu_ctrl.sv]
// Controller of the interval latency statistics unit: decodes accepted beats
// and sequences the datapath. Uses ilsu_pkg.
`default_nettype none
`include "interval_latency_statistics_unit_defines.svh"

module ilsu_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [ilsu_pkg::OP_W-1:0]   in_op,
  input  wire ilsu_pkg::dp_sts_t           sts,
  output ilsu_pkg::dp_cmd_t                cmd
);
  import ilsu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_FIN,
    S_DIV,
    S_REP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_START: cmd.load_start = 1'b1;
            OP_STOP: begin
              if (sts.armed) begin
                cmd.load_diff = 1'b1;
                state_nxt     = S_MUL;
              end
            end
            OP_REPORT: begin
              cmd.div_init = 1'b1;
              state_nxt    = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.accum_mode) begin
          cmd.stat_upd = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_REP;
        end
      end
      S_REP: begin
        if (sts.out_free) begin
          cmd.emit_report = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ILSU_ASSERT_NEXT(a_stop_starts_mul, accept && in_op == OP_STOP && sts.armed, state_r == S_MUL, "armed stop did not start the multiply")
  `ILSU_ASSERT_NEXT(a_mul_then_add, state_r == S_MUL, state_r == S_ADD, "multiply not followed by add")
  `ILSU_ASSERT_NEXT(a_div_ends, state_r == S_DIV && sts.div_last, state_r == S_REP, "divider end missed")

endmodule

`default_nettype wire

[src/interval_latency_statistics_unit.sv]
// Top level of the interval latency statistics unit: controller plus datapath.
// Depends on ilsu_pkg, ilsu_ctrl and ilsu_datapath.
//
//   Channel  Direction  Payload
//   in_      slave      tuser: op; tdata: stamp_sec, stamp_nsec
//   out_     master     tuser: kind; tdata: interval, min, avg, max, count
//   cfg_     slave      data: accum_mode
//
// A start beat or an ignored beat leaves the controller idle. A stop beat runs
// multiply, add and finish states; a report beat, the one-bit-per-cycle divider.
// Reset is synchronous and active low and clears the stamp, mode and statistics.
// A waiting result holds in the output register while new beats are taken;
// the block stalls only when a second result is ready before the first is taken.
`default_nettype none

module interval_latency_statistics_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] stamp_sec, [61:32] stamp_nsec, [63:62] zero
  input  wire logic [ilsu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] op
  input  wire logic [ilsu_pkg::OP_W-1:0]         in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [63:0] interval_ns, [127:64] min_ns, [191:128] avg_ns,
  // [255:192] max_ns, [287:256] sample_count
  output logic [ilsu_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] kind
  output logic                                   out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data
);
  import ilsu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ilsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  ilsu_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .stamp_sec  (in_tdata[SEC_W-1:0]),
    .stamp_nsec (in_tdata[SEC_W+NSEC_W-1:SEC_W]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[test/interval_latency_statistics_unit_test.sv]
// Self-checking testbench for interval_latency_statistics_unit: start, stop and report
// beats go in with random bursts and gaps, and each result is checked against a predictor.
// Depends on ilsu_pkg and the unit's RTL.
`default_nettype none

module interval_latency_statistics_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ilsu_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] NANOS_PER_SECOND = 64'd1_000_000_000;
  localparam logic [29:0] NSEC_TOP = 30'h3FFF_FFFF;
  localparam int SETTLE_CYCLES = 80;
  localparam int CHUNK_ITEMS = 150;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0] sec;
    logic [29:0] nsec;
  } stamp_beat_t;

  typedef struct packed {
    logic kind;
    logic [63:0] interval_ns;
    logic [63:0] min_ns;
    logic [63:0] avg_ns;
    logic [63:0] max_ns;
    logic [31:0] sample_count;
  } latency_result_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_style_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = OP_UNUSED;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  stamp_beat_t pending_beats[$];
  latency_result_t expected_results[$];

  logic [31:0] start_sec_q = '0;
  logic [29:0] start_nsec_q = '0;
  logic armed_q = 1'b0;
  logic accum_mode_q = 1'b0;
  logic [63:0] lat_sum = '0;
  logic [31:0] lat_count = '0;
  logic [63:0] lat_min = '0;
  logic [63:0] lat_max = '0;

  int error_count = 0;
  int beats_accepted = 0;
  int intervals_checked = 0;
  int reports_checked = 0;
  int mode_writes = 0;

  stamp_beat_t driven_beat;
  stamp_beat_t next_beat;
  int burst_left = 1;
  int gap_left = 0;
  ready_style_t ready_style = READY_ALWAYS;
  int style_left = 0;
  latency_result_t got_result;
  latency_result_t want_result;

  interval_latency_statistics_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic void predict_latency_result(input stamp_beat_t b);
    logic [63:0] sec_diff;
    logic [63:0] nsec_diff;
    logic [63:0] interval;
    latency_result_t r;
    r = '0;
    if (b.op == OP_START) begin
      start_sec_q = b.sec;
      start_nsec_q = b.nsec;
      armed_q = 1'b1;
    end else if (b.op == OP_STOP && armed_q) begin
      armed_q = 1'b0;
      sec_diff = {32'd0, b.sec} - {32'd0, start_sec_q};
      if (b.nsec < start_nsec_q) begin
        nsec_diff = {34'd0, b.nsec} - {34'd0, start_nsec_q} + NANOS_PER_SECOND;
        sec_diff = sec_diff - 64'd1;
      end else begin
        nsec_diff = {34'd0, b.nsec} - {34'd0, start_nsec_q};
      end
      interval = sec_diff * NANOS_PER_SECOND + nsec_diff;
      if (accum_mode_q) begin
        if (lat_count == 0 || interval < lat_min) lat_min = interval;
        if (interval > lat_max) lat_max = interval;
        lat_sum = lat_sum + interval;
        if (lat_count != 32'hFFFF_FFFF) lat_count = lat_count + 32'd1;
      end else begin
        r.kind = KIND_SINGLE;
        r.interval_ns = interval;
        expected_results.push_back(r);
      end
    end else if (b.op == OP_REPORT) begin
      r.kind = KIND_REPORT;
      r.min_ns = lat_min;
      r.avg_ns = (lat_count == 0) ? 64'd0 : lat_sum / {32'd0, lat_count};
      r.max_ns = lat_max;
      r.sample_count = lat_count;
      expected_results.push_back(r);
      lat_sum = '0;
      lat_count = '0;
      lat_min = '0;
      lat_max = '0;
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: bursts of beats from the pending queue, separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_latency_result(driven_beat);
        beats_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          next_beat = pending_beats.pop_front();
          driven_beat = next_beat;
          in_tuser <= next_beat.op;
          in_tdata <= {2'b00, next_beat.nsec, next_beat.sec};
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the result channel by changing styles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_result.kind = out_tuser;
        got_result.interval_ns = out_tdata[63:0];
        got_result.min_ns = out_tdata[127:64];
        got_result.avg_ns = out_tdata[191:128];
        got_result.max_ns = out_tdata[255:192];
        got_result.sample_count = out_tdata[287:256];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual kind %0d interval %0d",
                   $time, got_result.kind, got_result.interval_ns);
          error_count++;
        end else begin
          want_result = expected_results.pop_front();
          check_field("kind", {63'd0, want_result.kind}, {63'd0, got_result.kind});
          check_field("interval_ns", want_result.interval_ns, got_result.interval_ns);
          check_field("min_ns", want_result.min_ns, got_result.min_ns);
          check_field("avg_ns", want_result.avg_ns, got_result.avg_ns);
          check_field("max_ns", want_result.max_ns, got_result.max_ns);
          check_field("sample_count", {32'd0, want_result.sample_count},
                      {32'd0, got_result.sample_count});
          if (want_result.kind == KIND_REPORT) reports_checked++;
          else intervals_checked++;
        end
      end
      if (style_left <= 0) begin
        ready_style = ready_style_t'($urandom_range(0, 2));
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      case (ready_style)
        READY_ALWAYS: begin
          out_tready <= 1'b1;
        end
        READY_COIN: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  task automatic add_beat(input logic [OP_W-1:0] op, input logic [31:0] sec,
                          input logic [29:0] nsec);
    stamp_beat_t b;
    b.op = op;
    b.sec = sec;
    b.nsec = nsec;
    pending_beats.push_back(b);
  endtask

  task automatic wait_until_idle();
    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_accum_mode(input logic mode);
    wait_until_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    accum_mode_q = mode;
    mode_writes++;
  endtask

  function automatic logic [29:0] random_nsec();
    if ($urandom_range(0, 9) == 0) return 30'($urandom_range(0, NSEC_TOP));
    return 30'($urandom_range(0, 999_999_999));
  endfunction

  task automatic add_random_traffic(input int count);
    int added;
    int pick;
    logic [31:0] sec;
    logic [29:0] nsec;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        sec = $urandom();
        nsec = random_nsec();
        if ($urandom_range(0, 9) == 0) begin
          add_beat(OP_START, $urandom(), random_nsec());
          added++;
        end
        add_beat(OP_START, sec, nsec);
        pick = $urandom_range(0, 9);
        if (pick == 0) sec = $urandom();
        else if (pick == 1) sec = sec - 32'd1;
        else sec = sec + 32'($urandom_range(0, 2));
        add_beat(OP_STOP, sec, random_nsec());
        added += 2;
      end else if (pick < 82) begin
        add_beat(OP_REPORT, $urandom(), random_nsec());
        added++;
      end else if (pick < 90) begin
        add_beat(OP_STOP, $urandom(), random_nsec());
        added++;
      end else if (pick < 95) begin
        add_beat(OP_UNUSED, $urandom(), random_nsec());
      end else begin
        add_beat(OP_START, $urandom(), random_nsec());
        added++;
      end
    end
  endtask

  initial begin
    logic chunk_modes[7];
    chunk_modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    add_beat(OP_STOP, 32'd5, 30'd5);
    add_beat(OP_UNUSED, 32'hFFFF_FFFF, NSEC_TOP);
    add_beat(OP_REPORT, 32'd0, 30'd0);
    add_beat(OP_START, 32'd0, 30'd0);
    add_beat(OP_STOP, 32'd0, 30'd0);
    add_beat(OP_START, 32'd0, 30'd0);
    add_beat(OP_STOP, 32'hFFFF_FFFF, 30'd999_999_999);
    add_beat(OP_START, 32'hFFFF_FFFF, 30'd999_999_999);
    add_beat(OP_STOP, 32'd0, 30'd0);
    add_beat(OP_START, 32'd10, 30'd900_000_000);
    add_beat(OP_STOP, 32'd11, 30'd100_000_000);
    add_beat(OP_START, 32'd1, 30'd0);
    add_beat(OP_STOP, 32'd1, NSEC_TOP);
    add_beat(OP_START, 32'd1, 30'd5);
    add_beat(OP_START, 32'd2, 30'd7);
    add_beat(OP_STOP, 32'd3, 30'd0);
    add_beat(OP_STOP, 32'd3, 30'd0);
    write_accum_mode(1'b1);
    add_beat(OP_START, 32'd100, 30'd0);
    add_beat(OP_STOP, 32'd100, 30'd50);
    add_beat(OP_START, 32'd0, 30'd0);
    add_beat(OP_STOP, 32'd0, 30'd7);
    add_beat(OP_STOP, 32'd9, 30'd9);
    add_beat(OP_REPORT, 32'd0, 30'd0);
    add_beat(OP_REPORT, 32'd0, 30'd0);
    add_beat(OP_START, 32'd0, 30'd0);
    add_beat(OP_STOP, 32'd0, 30'd999);
    write_accum_mode(1'b0);
    add_beat(OP_REPORT, 32'd0, 30'd0);

    foreach (chunk_modes[i]) begin
      write_accum_mode(chunk_modes[i]);
      add_random_traffic(CHUNK_ITEMS);
    end

    wait_until_idle();
    $display("Covered %0d accepted beats over %0d mode writes.", beats_accepted, mode_writes);
    $display("Checked %0d single intervals and %0d statistics reports.",
             intervals_checked, reports_checked);
    if (error_count == 0) begin
      $display("interval_latency_statistics_unit_test passed");
    end else begin
      $display("interval_latency_statistics_unit_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("interval_latency_statistics_unit_test failed");
    $finish;
  end

endmodule

`default_nettype wire
